// ===== hw/rtl/lsdc_pkg.sv =====
`timescale 1ns / 1ps
package lsdc_pkg;

    // Input item kinds
    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_CONVERT = 1'b1
    } opcode_t;

    // Month walk constants
    localparam int MONTH_SLOTS = 13;
    localparam int LONG_DAYS   = 30;
    localparam int SHORT_DAYS  = 29;
    localparam int CYCLE_LEN   = 6;

    // One year of the table
    typedef struct packed {
        logic [3:0]  leap_after;
        logic [12:0] long_months;
        logic [8:0]  new_year_day;
    } year_entry_t;

    // Stage enables from the pipeline control
    typedef struct packed {
        logic en_a;
        logic en_b;
        logic en_c;
        logic en_d;
        logic en_o;
    } pipe_en_t;

    // Front end result handed to the month walk
    typedef struct packed {
        logic        valid_date;
        logic        malformed;
        logic [9:0]  since;
        logic [12:0] long_months;
        logic [3:0]  leap_after;
    } walk_in_t;

endpackage

// ===== hw/rtl/lsdc_year_mem.sv =====
`timescale 1ns / 1ps
module lsdc_year_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  lsdc_pkg::year_entry_t wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr_cur,
    input  logic [AW-1:0]         rd_addr_prev,
    output lsdc_pkg::year_entry_t rd_cur,
    output lsdc_pkg::year_entry_t rd_prev
);
    import lsdc_pkg::*;

    year_entry_t mem [0:DEPTH-1];
    year_entry_t rd_cur_reg;
    year_entry_t rd_prev_reg;

    // Single write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Two registered read ports, held while the stage is stalled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_cur_reg  <= mem[rd_addr_cur];
            rd_prev_reg <= mem[rd_addr_prev];
        end
    end

    assign rd_cur  = rd_cur_reg;
    assign rd_prev = rd_prev_reg;

endmodule

// ===== hw/rtl/lsdc_date_front.sv =====
`timescale 1ns / 1ps
module lsdc_date_front (
    input  logic                  clk,
    input  lsdc_pkg::pipe_en_t    en,
    input  logic [11:0]           year,
    input  logic [3:0]            month,
    input  logic [4:0]            day,
    input  logic                  in_range,
    input  logic                  at_first,
    input  lsdc_pkg::year_entry_t rd_cur,
    input  lsdc_pkg::year_entry_t rd_prev,
    output lsdc_pkg::walk_in_t    walk_in
);
    import lsdc_pkg::*;

    // Inverse of 25 modulo 2^12: y is a multiple of 25 iff y*inv mod 2^12 <= 163
    localparam logic [11:0] INV25    = 12'd3113;
    localparam logic [11:0] MAX_Q25  = 12'd163;

    function automatic logic is_leap(input logic [11:0] y);
        logic [23:0] p;
        logic        div25;
        p     = 24'(y) * 24'(INV25);
        div25 = (p[11:0] <= MAX_Q25);
        return ((y[1:0] == 2'd0) && !div25) || ((y[3:0] == 4'd0) && div25);
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] m, input logic lp);
        logic [8:0] d;
        case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd365;
        endcase
        if (lp && (m >= 4'd3))
        begin
            d = d + 9'd1;
        end
        return d;
    endfunction

    // Stage A: request fields beside the table read
    logic [11:0] a_year_reg;
    logic [3:0]  a_month_reg;
    logic [4:0]  a_day_reg;
    logic        a_in_range_reg;
    logic        a_at_first_reg;

    always_ff @(posedge clk)
    begin
        if (en.en_a)
        begin
            a_year_reg     <= year;
            a_month_reg    <= month;
            a_day_reg      <= day;
            a_in_range_reg <= in_range;
            a_at_first_reg <= at_first;
        end
    end

    // Stage B: leap rules and day of year
    logic       leap_cur;
    logic       leap_prev;
    logic [8:0] doy_next;

    always_comb
    begin
        leap_cur  = is_leap(a_year_reg);
        leap_prev = is_leap(a_year_reg - 12'd1);
        doy_next  = days_before(a_month_reg, leap_cur)
                  + ((a_day_reg == 5'd0) ? 9'd0 : 9'(a_day_reg - 5'd1));
    end

    logic [8:0]  b_doy_reg;
    logic        b_prev_leap_reg;
    logic        b_in_range_reg;
    logic        b_at_first_reg;
    year_entry_t b_cur_reg;
    year_entry_t b_prev_reg;

    always_ff @(posedge clk)
    begin
        if (en.en_b)
        begin
            b_doy_reg       <= doy_next;
            b_prev_leap_reg <= leap_prev;
            b_in_range_reg  <= a_in_range_reg;
            b_at_first_reg  <= a_at_first_reg;
            b_cur_reg       <= rd_cur;
            b_prev_reg      <= rd_prev;
        end
    end

    // Stage C: days since lunar new year, from this year or the previous one
    logic        use_cur;
    logic [8:0]  prev_len;
    logic [10:0] prev_span;
    logic [10:0] prev_sum;
    walk_in_t    walk_next;
    walk_in_t    c_reg;

    always_comb
    begin
        use_cur   = (b_doy_reg >= b_cur_reg.new_year_day);
        prev_len  = b_prev_leap_reg ? 9'd366 : 9'd365;
        prev_span = 11'(prev_len) + 11'(b_doy_reg);
        prev_sum  = prev_span - 11'(b_prev_reg.new_year_day);

        walk_next.valid_date = b_in_range_reg && (use_cur || !b_at_first_reg);
        if (use_cur)
        begin
            walk_next.malformed   = 1'b0;
            walk_next.since       = 10'(b_doy_reg - b_cur_reg.new_year_day);
            walk_next.long_months = b_cur_reg.long_months;
            walk_next.leap_after  = b_cur_reg.leap_after;
        end
        else
        begin
            walk_next.malformed   = (prev_span < 11'(b_prev_reg.new_year_day));
            walk_next.since       = prev_sum[9:0];
            walk_next.long_months = b_prev_reg.long_months;
            walk_next.leap_after  = b_prev_reg.leap_after;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.en_c)
        begin
            c_reg <= walk_next;
        end
    end

    assign walk_in = c_reg;

endmodule

// ===== hw/rtl/lsdc_month_walk.sv =====
`timescale 1ns / 1ps
module lsdc_month_walk (
    input  logic               clk,
    input  lsdc_pkg::pipe_en_t en,
    input  lsdc_pkg::walk_in_t walk_in,
    output logic               date_valid,
    output logic [3:0]         lunar_month,
    output logic               leap_flag,
    output logic [4:0]         lunar_day,
    output logic [2:0]         six_day_index
);
    import lsdc_pkg::*;

    // Stage D: month slot boundaries as prefix sums, compared in parallel
    logic [8:0] cum  [0:MONTH_SLOTS];
    logic [9:0] diff [0:MONTH_SLOTS];
    logic [3:0] cnt;
    logic [3:0] pc;
    logic [9:0] rem_sel;

    always_comb
    begin
        for (int k = 0; k <= MONTH_SLOTS; k++)
        begin
            pc = 4'd0;
            for (int j = 0; j < MONTH_SLOTS; j++)
            begin
                if (j < k)
                begin
                    pc = pc + {3'b0, walk_in.long_months[j]};
                end
            end
            cum[k]  = 9'(SHORT_DAYS * k) + {5'b0, pc};
            diff[k] = walk_in.since - {1'b0, cum[k]};
        end
        // boundaries rise strictly, so the last one passed is the slot count
        cnt = 4'd0;
        for (int k = 1; k <= MONTH_SLOTS; k++)
        begin
            if (walk_in.since >= {1'b0, cum[k]})
            begin
                cnt = 4'(k);
            end
        end
        rem_sel = diff[cnt];
    end

    logic       d_valid_reg;
    logic       d_malformed_reg;
    logic [3:0] d_count_reg;
    logic [4:0] d_rem_reg;
    logic [3:0] d_leap_after_reg;

    always_ff @(posedge clk)
    begin
        if (en.en_d)
        begin
            d_valid_reg      <= walk_in.valid_date;
            d_malformed_reg  <= walk_in.malformed || (cnt == 4'(MONTH_SLOTS));
            d_count_reg      <= cnt;
            d_rem_reg        <= rem_sel[4:0];
            d_leap_after_reg <= walk_in.leap_after;
        end
    end

    // Stage O: month number and leap flag from slots passed
    logic [3:0] mnum;
    logic       leap;
    logic [4:0] rem;
    logic [5:0] cyc;

    always_comb
    begin
        if ((d_leap_after_reg == 4'd0) || (d_count_reg < d_leap_after_reg))
        begin
            mnum = d_count_reg + 4'd1;
            leap = 1'b0;
        end
        else if (d_count_reg == d_leap_after_reg)
        begin
            mnum = d_leap_after_reg;
            leap = 1'b1;
        end
        else
        begin
            mnum = d_count_reg;
            leap = 1'b0;
        end
        rem = d_rem_reg;
        if (d_malformed_reg)
        begin
            mnum = 4'd12;
            leap = 1'b0;
            rem  = 5'd0;
        end
        // six-day position: reduce month-1+rem (below 42) by 24, 12, 6
        cyc = {2'b0, mnum} - 6'd1 + {1'b0, rem};
        if (cyc >= 6'(4 * CYCLE_LEN))
        begin
            cyc = cyc - 6'(4 * CYCLE_LEN);
        end
        if (cyc >= 6'(2 * CYCLE_LEN))
        begin
            cyc = cyc - 6'(2 * CYCLE_LEN);
        end
        if (cyc >= 6'(CYCLE_LEN))
        begin
            cyc = cyc - 6'(CYCLE_LEN);
        end
    end

    logic       date_valid_reg;
    logic [3:0] lunar_month_reg;
    logic       leap_flag_reg;
    logic [4:0] lunar_day_reg;
    logic [2:0] six_day_index_reg;

    // Output register; an out-of-table date reads all zero
    always_ff @(posedge clk)
    begin
        if (en.en_o)
        begin
            date_valid_reg    <= d_valid_reg;
            lunar_month_reg   <= d_valid_reg ? mnum : 4'd0;
            leap_flag_reg     <= d_valid_reg && leap;
            lunar_day_reg     <= d_valid_reg ? (rem + 5'd1) : 5'd0;
            six_day_index_reg <= d_valid_reg ? cyc[2:0] : 3'd0;
        end
    end

    assign date_valid    = date_valid_reg;
    assign lunar_month   = lunar_month_reg;
    assign leap_flag     = leap_flag_reg;
    assign lunar_day     = lunar_day_reg;
    assign six_day_index = six_day_index_reg;

endmodule

// ===== hw/rtl/lunisolar_date_converter.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Moves
// cfg       in         cfg_wr_en            table_first_year (cfg_wr_data)
// in        in         in_valid / in_ready  load or convert item
// out       out        out_valid / out_ready one result per convert item
//
// One transfer per cycle on in while in_ready is high; a convert result passes
// through the registered table read, day-of-year, new-year select, slot compare
// and output stages in that order and is presented on out from the output stage.
// A load writes its table entry at the transfer edge and gives no result.
// Reset clears the stage valids and sets the first table year to 1900; the table
// itself is not cleared.
// A stalled out channel holds the occupied stages in place, empty stages still fill,
// and in_ready drops once the pipeline is full.
module lunisolar_date_converter #(
    parameter int TABLE_YEARS = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [11:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [6:0]  table_index,
    input  logic [8:0]  entry_new_year_day,
    input  logic [12:0] entry_long_months,
    input  logic [3:0]  entry_leap_after,
    input  logic [11:0] greg_year,
    input  logic [3:0]  greg_month,
    input  logic [4:0]  greg_day,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        date_valid,
    output logic [3:0]  lunar_month,
    output logic        leap_flag,
    output logic [4:0]  lunar_day,
    output logic [2:0]  six_day_index
);
    import lsdc_pkg::*;

    localparam int AW = (TABLE_YEARS > 1) ? $clog2(TABLE_YEARS) : 1;

    // Configuration register
    logic [11:0] table_first_year_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_first_year_reg <= 12'd1900;
        end
        else if (cfg_wr_en)
        begin
            table_first_year_reg <= cfg_wr_data;
        end
    end

    // Pipeline control: each stage moves when empty or when the next one moves
    logic     v_a_reg, v_b_reg, v_c_reg, v_d_reg, v_o_reg;
    pipe_en_t en;
    logic     in_xfer;

    always_comb
    begin
        en.en_o = !v_o_reg || out_ready;
        en.en_d = !v_d_reg || en.en_o;
        en.en_c = !v_c_reg || en.en_d;
        en.en_b = !v_b_reg || en.en_c;
        en.en_a = !v_a_reg || en.en_b;
    end

    assign in_ready  = en.en_a;
    assign in_xfer   = in_valid && en.en_a;
    assign out_valid = v_o_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
            v_c_reg <= 1'b0;
            v_d_reg <= 1'b0;
            v_o_reg <= 1'b0;
        end
        else
        begin
            if (en.en_a)
            begin
                v_a_reg <= in_valid && (opcode == OP_CONVERT);
            end
            if (en.en_b)
            begin
                v_b_reg <= v_a_reg;
            end
            if (en.en_c)
            begin
                v_c_reg <= v_b_reg;
            end
            if (en.en_d)
            begin
                v_d_reg <= v_c_reg;
            end
            if (en.en_o)
            begin
                v_o_reg <= v_d_reg;
            end
        end
    end

    // Table write for load items
    logic          wr_en;
    logic [AW+6:0] wr_wide;
    logic [AW-1:0] wr_addr;
    year_entry_t   wr_data;

    always_comb
    begin
        wr_en   = in_xfer && (opcode == OP_LOAD) && (32'(table_index) < TABLE_YEARS);
        wr_wide = (AW + 7)'(table_index);
        wr_addr = wr_wide[AW-1:0];
        wr_data.new_year_day = entry_new_year_day;
        wr_data.long_months  = entry_long_months;
        wr_data.leap_after   = entry_leap_after;
    end

    // Table addresses for this year and the previous one
    logic [11:0]    year_diff;
    logic           in_range;
    logic           at_first;
    logic [AW+11:0] rd_wide;
    logic [AW-1:0]  rd_addr_cur;
    logic [AW-1:0]  rd_addr_prev;

    always_comb
    begin
        year_diff    = greg_year - table_first_year_reg;
        in_range     = (greg_year >= table_first_year_reg)
                    && (32'(year_diff) < TABLE_YEARS);
        at_first     = (greg_year == table_first_year_reg);
        rd_wide      = (AW + 12)'(year_diff);
        rd_addr_cur  = rd_wide[AW-1:0];
        rd_addr_prev = rd_addr_cur - AW'(1);
    end

    year_entry_t rd_cur;
    year_entry_t rd_prev;
    walk_in_t    walk_in;

    lsdc_year_mem #(
        .DEPTH (TABLE_YEARS),
        .AW    (AW)
    ) u_mem (
        .clk          (clk),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_en        (en.en_a),
        .rd_addr_cur  (rd_addr_cur),
        .rd_addr_prev (rd_addr_prev),
        .rd_cur       (rd_cur),
        .rd_prev      (rd_prev)
    );

    lsdc_date_front u_front (
        .clk      (clk),
        .en       (en),
        .year     (greg_year),
        .month    (greg_month),
        .day      (greg_day),
        .in_range (in_range),
        .at_first (at_first),
        .rd_cur   (rd_cur),
        .rd_prev  (rd_prev),
        .walk_in  (walk_in)
    );

    lsdc_month_walk u_walk (
        .clk           (clk),
        .en            (en),
        .walk_in       (walk_in),
        .date_valid    (date_valid),
        .lunar_month   (lunar_month),
        .leap_flag     (leap_flag),
        .lunar_day     (lunar_day),
        .six_day_index (six_day_index)
    );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import lsdc_pkg::*;

    localparam int TABLE_DEPTH  = 128;
    localparam int SETTLE_TICKS = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SEGMENTS     = 6;
    localparam int ITEMS_PER_SEGMENT = 50;
    localparam int MAX_YEAR     = 4095;

    // One input item as seen on the in channel
    typedef struct {
        opcode_t     op;
        logic [6:0]  table_index;
        year_entry_t entry;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } lunar_item_t;

    // One result as seen on the out channel
    typedef struct packed {
        logic       date_valid;
        logic [3:0] lunar_month;
        logic       leap_flag;
        logic [4:0] lunar_day;
        logic [2:0] six_day_index;
    } lunar_date_t;

    // Table copy, register copy and the dates still owed by the block
    class lunar_scoreboard;
        year_entry_t year_table[TABLE_DEPTH];
        int          first_year = 1900;
        lunar_date_t pending_dates[$];
        int          mismatches = 0;
        int          loads = 0;
        int          converts = 0;
        int          in_range = 0;

        function bit is_leap(int y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function int month_length(int m, int y);
            if (m == 2) return is_leap(y) ? 29 : 28;
            if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
            return 31;
        endfunction

        // Gregorian date to lunisolar date with the current table
        function lunar_date_t lunar_date_of(logic [11:0] year, logic [3:0] month,
                                            logic [4:0] day);
            lunar_date_t r;
            year_entry_t e;
            int          y, doy, since, mnum, rem, slot, len, m;
            bit          leap, bad, done;
            r = '0;
            y = int'(year);
            if (y < first_year || y > first_year + TABLE_DEPTH - 1) return r;
            doy = 0;
            for (m = 1; m < int'(month) && m <= 12; m++) doy += month_length(m, y);
            if (day > 0) doy += int'(day) - 1;
            e = year_table[y - first_year];
            if (doy >= int'(e.new_year_day)) begin
                since = doy - int'(e.new_year_day);
            end else begin
                // before new year: walk from last year's entry
                if (y == first_year) return r;
                e = year_table[y - 1 - first_year];
                since = (is_leap(y - 1) ? 366 : 365) - int'(e.new_year_day) + doy;
            end
            bad  = (since < 0);
            mnum = 1;
            leap = 1'b0;
            rem  = bad ? 0 : since;
            done = 1'b0;
            if (!bad) begin
                for (slot = 0; slot < MONTH_SLOTS && !done; slot++) begin
                    len = e.long_months[slot] ? LONG_DAYS : SHORT_DAYS;
                    if (rem < len) begin
                        done = 1'b1;
                    end else begin
                        rem -= len;
                        if (mnum == int'(e.leap_after) && !leap) begin
                            leap = 1'b1;
                        end else begin
                            mnum++;
                            leap = 1'b0;
                        end
                    end
                end
                if (!done) bad = 1'b1;
            end
            if (bad) begin
                mnum = 12;
                leap = 1'b0;
                rem  = 0;
            end
            r.date_valid    = 1'b1;
            r.lunar_month   = 4'(mnum);
            r.leap_flag     = leap;
            r.lunar_day     = 5'(rem + 1);
            r.six_day_index = 3'((mnum + rem - 1) % CYCLE_LEN);
            return r;
        endfunction

        // Called at the edge where an input transfer happens
        function void note_transfer(lunar_item_t it);
            lunar_date_t d;
            if (it.op == OP_LOAD) begin
                loads++;
                if (int'(it.table_index) < TABLE_DEPTH) year_table[it.table_index] = it.entry;
            end else begin
                converts++;
                d = lunar_date_of(it.year, it.month, it.day);
                if (d.date_valid) in_range++;
                pending_dates.push_back(d);
            end
        endfunction

        task report(string what, int got, int want);
            $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
            mismatches++;
        endtask

        task check_result(lunar_date_t got);
            lunar_date_t want;
            if (pending_dates.size() == 0) begin
                report("result with nothing pending, date_valid", got.date_valid, 0);
            end else begin
                want = pending_dates.pop_front();
                if (got.date_valid != want.date_valid)
                    report("date_valid", got.date_valid, want.date_valid);
                if (got.lunar_month != want.lunar_month)
                    report("lunar_month", got.lunar_month, want.lunar_month);
                if (got.leap_flag != want.leap_flag)
                    report("leap_flag", got.leap_flag, want.leap_flag);
                if (got.lunar_day != want.lunar_day)
                    report("lunar_day", got.lunar_day, want.lunar_day);
                if (got.six_day_index != want.six_day_index)
                    report("six_day_index", got.six_day_index, want.six_day_index);
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [11:0] cfg_wr_data;
    logic        in_valid;
    logic        in_ready;
    logic        opcode;
    logic [6:0]  table_index;
    logic [8:0]  entry_new_year_day;
    logic [12:0] entry_long_months;
    logic [3:0]  entry_leap_after;
    logic [11:0] greg_year;
    logic [3:0]  greg_month;
    logic [4:0]  greg_day;
    logic        out_valid;
    logic        out_ready;
    logic        date_valid;
    logic [3:0]  lunar_month;
    logic        leap_flag;
    logic [4:0]  lunar_day;
    logic [2:0]  six_day_index;

    lunar_scoreboard sb = new();
    lunar_date_t     seen;
    int              idle_pct  = 0;
    int              stall_pct = 0;
    int              cycles    = 0;
    int              settings  = 0;

    lunisolar_date_converter #(.TABLE_YEARS(TABLE_DEPTH)) dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .opcode             (opcode),
        .table_index        (table_index),
        .entry_new_year_day (entry_new_year_day),
        .entry_long_months  (entry_long_months),
        .entry_leap_after   (entry_leap_after),
        .greg_year          (greg_year),
        .greg_month         (greg_month),
        .greg_day           (greg_day),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .date_valid         (date_valid),
        .lunar_month        (lunar_month),
        .leap_flag          (leap_flag),
        .lunar_day          (lunar_day),
        .six_day_index      (six_day_index)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // Result side: check each out transfer, stall at random
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen.date_valid    = date_valid;
            seen.lunar_month   = lunar_month;
            seen.leap_flag     = leap_flag;
            seen.lunar_day     = lunar_day;
            seen.six_day_index = six_day_index;
            sb.check_result(seen);
        end
        out_ready <= (int'($urandom_range(99)) >= stall_pct);
    end

    function automatic lunar_item_t load_item(logic [6:0] idx, year_entry_t e);
        lunar_item_t it;
        it.op          = OP_LOAD;
        it.table_index = idx;
        it.entry       = e;
        it.year        = 12'($urandom_range(MAX_YEAR));
        it.month       = 4'($urandom_range(12, 1));
        it.day         = 5'($urandom_range(31, 1));
        return it;
    endfunction

    function automatic lunar_item_t convert_item(int y, int m, int d);
        lunar_item_t it;
        it.op          = OP_CONVERT;
        it.table_index = 7'($urandom_range(TABLE_DEPTH - 1));
        it.entry       = year_entry_t'(26'($urandom()));
        it.entry.new_year_day = 9'($urandom_range(365));
        it.entry.leap_after   = 4'($urandom_range(12));
        it.year        = 12'(y);
        it.month       = 4'(m);
        it.day         = 5'(d);
        return it;
    endfunction

    // Mostly plausible years, some with new year anywhere in the year
    function automatic year_entry_t random_entry();
        year_entry_t e;
        e.long_months = 13'($urandom_range(8191));
        e.leap_after  = ($urandom_range(99) < 50) ? 4'd0 : 4'($urandom_range(12, 1));
        if ($urandom_range(99) < 75)
            e.new_year_day = 9'($urandom_range(50, 20));
        else
            e.new_year_day = 9'($urandom_range(365));
        return e;
    endfunction

    function automatic lunar_item_t random_item(int first);
        int span;
        int y;
        if ($urandom_range(99) < 15)
            return load_item(7'($urandom_range(TABLE_DEPTH - 1)), random_entry());
        span = (MAX_YEAR - first < TABLE_DEPTH - 1) ? MAX_YEAR - first : TABLE_DEPTH - 1;
        if ($urandom_range(99) < 85)
            y = first + int'($urandom_range(span));
        else
            y = int'($urandom_range(MAX_YEAR));
        return convert_item(y, int'($urandom_range(12, 1)), int'($urandom_range(31, 1)));
    endfunction

    // Present one item, with random idle cycles ahead of it
    task drive_item(input lunar_item_t it);
        while (int'($urandom_range(99)) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid           <= 1'b1;
        opcode             <= it.op;
        table_index        <= it.table_index;
        entry_new_year_day <= it.entry.new_year_day;
        entry_long_months  <= it.entry.long_months;
        entry_leap_after   <= it.entry.leap_after;
        greg_year          <= it.year;
        greg_month         <= it.month;
        greg_day           <= it.day;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_transfer(it);
    endtask

    // Hold input off until every owed result is out, then let the pipe settle
    task wait_idle();
        in_valid <= 1'b0;
        while (sb.pending_dates.size() != 0) @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task write_first_year(input int value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= 12'(value);
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
        sb.first_year = value;
        settings++;
    endtask

    // Stimulus
    initial
    begin
        int          seg;
        int          i;
        int          fy;
        int          idle_plan[SEGMENTS];
        int          stall_plan[SEGMENTS];
        idle_plan  = '{0, 63, 0, 30, 0, 30};
        stall_plan = '{0, 0, 63, 30, 0, 30};

        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        in_valid           = 1'b0;
        out_ready          = 1'b0;
        opcode             = 1'b0;
        table_index        = '0;
        entry_new_year_day = '0;
        entry_long_months  = '0;
        entry_leap_after   = '0;
        greg_year          = '0;
        greg_month         = 4'd1;
        greg_day           = 5'd1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset first year (1900), hand-picked table entries
        drive_item(load_item(7'd0,   year_entry_t'({4'd0,  13'h0AAA, 9'd30})));
        drive_item(load_item(7'd1,   year_entry_t'({4'd4,  13'h1555, 9'd40})));
        drive_item(load_item(7'd100, year_entry_t'({4'd8,  13'h0F0F, 9'd35})));
        drive_item(load_item(7'd124, year_entry_t'({4'd12, 13'h1FFF, 9'd0})));
        drive_item(load_item(7'd127, year_entry_t'({4'd0,  13'h0000, 9'd0})));
        // outside the table on both sides
        drive_item(convert_item(0, 1, 1));
        drive_item(convert_item(MAX_YEAR, 12, 31));
        drive_item(convert_item(1899, 6, 15));
        drive_item(convert_item(2028, 1, 1));
        // first table year, before its new year
        drive_item(convert_item(1900, 1, 1));
        // before new year, previous entry used
        drive_item(convert_item(1901, 1, 5));
        // 1900 is not a leap year; day past month end
        drive_item(convert_item(1900, 3, 1));
        drive_item(convert_item(1900, 2, 31));
        // leap month after month 4
        drive_item(convert_item(1901, 8, 15));
        // 2000 is a leap year
        drive_item(convert_item(2000, 2, 29));
        drive_item(convert_item(2000, 7, 4));
        drive_item(convert_item(2000, 12, 31));
        // leap month after month 12, all long months
        drive_item(convert_item(2024, 1, 1));
        drive_item(convert_item(2024, 12, 31));
        // thirteenth ordinary month
        drive_item(convert_item(2027, 12, 31));
        drive_item(convert_item(2027, 1, 1));
        wait_idle();

        // Fill every entry so later conversions only read loaded years
        for (i = 0; i < TABLE_DEPTH; i++)
            drive_item(load_item(7'(i), random_entry()));

        // Random segments, each with its own first year and idle pattern
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            wait_idle();
            case (seg)
                0: fy = 1900;
                1: fy = 0;
                2: fy = MAX_YEAR;
                3: fy = int'($urandom_range(MAX_YEAR));
                4: fy = int'($urandom_range(2100, 1800));
                default: fy = int'($urandom_range(MAX_YEAR, MAX_YEAR - TABLE_DEPTH + 1));
            endcase
            write_first_year(fy);
            idle_pct  = idle_plan[seg];
            stall_pct = stall_plan[seg];
            repeat (ITEMS_PER_SEGMENT) drive_item(random_item(fy));
        end

        wait_idle();
        $display("covered %0d table loads and %0d conversions (%0d inside the table)",
                 sb.loads, sb.converts, sb.in_range);
        $display("over %0d first-year settings, %0d mismatches", settings, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_dates.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
